// ----- design/pfp_pkg.sv -----
// shared constants, phase type and control struct for the pose frame parser
`default_nettype none

package pfp_pkg;

  // frame bytes
  localparam logic [7:0] HDR_CR = 8'h0D;
  localparam logic [7:0] HDR_LF = 8'h0A;

  // payload geometry
  localparam int unsigned PAYLOAD_LEN = 24;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_BYTES  = WORD_W / BYTE_W;
  localparam int unsigned OUT_W       = 3 * WORD_W;

  // payload word slots (byte index divided by four)
  localparam logic [2:0] WSEL_ANGLE = 3'd0;
  localparam logic [2:0] WSEL_X     = 3'd3;
  localparam logic [2:0] WSEL_Y     = 3'd4;

  // last payload slot
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LF   = 3'd1,
    PH_DATA = 3'd2,
    PH_TLF  = 3'd3,
    PH_TCR  = 3'd4
  } phase_t;

  // deframer to datapath control
  typedef struct packed {
    phase_t           phase;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             emit;
  } pfp_ctl_t;

endpackage

`default_nettype wire

// ----- design/pfp_deframer.sv -----
// frame state machine: tracks header, payload slot and trailer
`default_nettype none

module pfp_deframer
  import pfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              beat_ok,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output pfp_ctl_t               ctl
);

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (beat_ok) begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = (rx_byte == HDR_CR) ? PH_LF : PH_IDLE;
        end
        PH_LF: begin
          if (rx_byte == HDR_LF) begin
            idx_nxt   = '0;
            phase_nxt = PH_DATA;
          end else if (rx_byte != HDR_CR) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATA: begin
          // the last slot, or an out of range index, closes the payload
          if (idx_r >= IDX_LAST) begin
            idx_nxt   = '0;
            phase_nxt = PH_TLF;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        PH_TLF: begin
          phase_nxt = (rx_byte == HDR_LF) ? PH_TCR : PH_IDLE;
        end
        PH_TCR: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    ctl.phase  = phase_r;
    ctl.wr_idx = idx_r;
    ctl.wr_en  = beat_ok && (phase_r == PH_DATA) && (idx_r <= IDX_LAST);
    ctl.emit   = beat_ok && (phase_r == PH_TCR) && (rx_byte == HDR_CR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/pose_frame_parser.sv -----
// pose frame parser top level: deframer, payload capture and result register
//
//  channel | dir | beat contents
//  in_     | in  | tdata[7:0] rx_byte
//  out_    | out | tdata[31:0] angle_bits, [63:32] x_bits, [95:64] y_bits
//
// one byte per cycle while in_tready is high; the result appears in the cycle
// after the closing byte. synchronous active-low reset returns the deframer
// to idle and drops any pending result; captured payload bytes are not cleared.
// while a result waits on out_tready, bytes keep flowing in; only a byte
// arriving in the closing-byte phase is held off until the result is taken.
`default_nettype none

module pose_frame_parser
  import pfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [OUT_W-1:0]  out_tdata   // [31:0] angle_bits, [63:32] x_bits,
                                             // [95:64] y_bits
);

  pfp_ctl_t          ctl;
  logic              beat_ok;
  logic [BYTE_W-1:0] angle_b_r [WORD_BYTES];
  logic [BYTE_W-1:0] x_b_r     [WORD_BYTES];
  logic [BYTE_W-1:0] y_b_r     [WORD_BYTES];
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [WORD_W-1:0] angle_w, x_w, y_w;
  logic [2:0]        wsel;
  logic [1:0]        lane;

  // hold off only a closing byte while the result register is stalled
  assign in_tready = !(out_valid_r && !out_tready && (ctl.phase == PH_TCR));
  assign beat_ok   = in_tvalid && in_tready;

  pfp_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_ok (beat_ok),
    .rx_byte (in_tdata),
    .ctl     (ctl)
  );

  // capture only the payload bytes that feed the result
  assign wsel = ctl.wr_idx[IDX_W-1:2];
  assign lane = ctl.wr_idx[1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      unique case (wsel)
        WSEL_ANGLE: angle_b_r[lane] <= in_tdata;
        WSEL_X:     x_b_r[lane]     <= in_tdata;
        WSEL_Y:     y_b_r[lane]     <= in_tdata;
        default:    ;
      endcase
    end
  end

  // little-endian words, x and y negated through the sign bit
  assign angle_w = {angle_b_r[3], angle_b_r[2], angle_b_r[1], angle_b_r[0]};
  assign x_w     = {~x_b_r[3][BYTE_W-1], x_b_r[3][BYTE_W-2:0],
                    x_b_r[2], x_b_r[1], x_b_r[0]};
  assign y_w     = {~y_b_r[3][BYTE_W-1], y_b_r[3][BYTE_W-2:0],
                    y_b_r[2], y_b_r[1], y_b_r[0]};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r <= {y_w, x_w, angle_w};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result only follows an accepted closing byte
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.emit))
    else $error("result appeared without a closing byte");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !ctl.emit)
    else $error("pending result overwritten");

  // payload writes stay inside the frame
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> (ctl.wr_idx <= IDX_LAST))
    else $error("payload write out of range");

  // a bad trailing byte drops the frame
  a_bad_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_ok && (ctl.phase == PH_TLF) && (in_tdata != HDR_LF))
      |=> (ctl.phase == PH_IDLE))
    else $error("bad trailer did not return to idle");

endmodule

`default_nettype wire
